// ----- src/u2l_pkg.sv -----
// Shared types, constants and a helper function for the UTF-8 to Latin-1 stream core.
package u2l_pkg;

    localparam int unsigned CntW  = 24;
    localparam int unsigned AccW  = 32;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = 2;
    localparam int unsigned QCntW  = 3;

    localparam logic [CntW-1:0] CNT_MAX     = 24'hFF_FFFF;
    localparam logic [CntW-1:0] CNT_ONE     = 24'd1;
    localparam logic [AccW-1:0] CP_LIMIT    = 32'h0010_FFFF;
    localparam logic [AccW-1:0] LATIN1_MAX  = 32'd255;
    localparam logic [7:0]      NEWLINE     = 8'h0A;
    localparam logic [7:0]      ASCII_MAX   = 8'h7F;
    localparam logic [7:0]      CONT_MAX    = 8'hBF;
    localparam logic [7:0]      LEAD2_MAX   = 8'hDF;
    localparam logic [7:0]      LEAD3_MAX   = 8'hEF;
    localparam logic [7:0]      CONT_MASK   = 8'h3F;
    localparam logic [7:0]      LEAD2_MASK  = 8'h1F;
    localparam logic [7:0]      LEAD3_MASK  = 8'h0F;
    localparam logic [7:0]      LEAD4_MASK  = 8'h07;
    localparam logic [1:0]      CONT_TAG    = 2'b10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } u2l_in_t;

    typedef struct packed {
        logic [7:0]      out_byte;
        logic            invalid_code;
        logic [CntW-1:0] line_number;
        logic [CntW-1:0] column_number;
        logic            last_of_run;
    } u2l_out_t;

    typedef struct packed {
        logic [AccW-1:0] acc;
        logic            pending;
        logic [CntW-1:0] line;
        logic [CntW-1:0] col;
    } u2l_state_t;

    // Results of one byte, already packed so that the first valid result sits in res_a.
    typedef struct packed {
        logic [1:0] n_res;
        u2l_out_t   res_a;
        u2l_out_t   res_b;
    } u2l_push_t;

    localparam u2l_state_t STATE_RESET = '{acc: '0, pending: 1'b0, line: CNT_ONE, col: CNT_ONE};

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_ONE;
    endfunction

endpackage

// ----- src/u2l_if.sv -----
// Valid/ready channel interfaces for the input bytes and the output characters.
interface u2l_in_if;
    import u2l_pkg::*;

    logic    valid;
    logic    ready;
    u2l_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface u2l_out_if;
    import u2l_pkg::*;

    logic     valid;
    logic     ready;
    u2l_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/u2l_decode.sv -----
// Per-byte decode: settles the waiting code point, absorbs the byte, computes next state.
module u2l_decode (
    input  u2l_pkg::u2l_in_t    item,
    input  u2l_pkg::u2l_state_t state,
    output u2l_pkg::u2l_state_t state_next,
    output u2l_pkg::u2l_push_t  push
);
    import u2l_pkg::*;

    logic              cont;
    logic              emit0;
    logic              emit1;
    logic [CntW-1:0]   col_a;
    logic [CntW-1:0]   col_b;
    logic [CntW-1:0]   line_b;
    logic [AccW-1:0]   acc_new;
    u2l_out_t          res0;
    u2l_out_t          res1;

    always_comb
    begin
        cont  = (item.in_byte[7:6] == CONT_TAG);
        emit0 = state.pending && !cont && (state.acc <= CP_LIMIT);
        col_a = emit0 ? sat_inc(state.col) : state.col;

        if (item.in_byte == NEWLINE)
        begin
            col_b  = CNT_ONE;
            line_b = sat_inc(state.line);
        end
        else
        begin
            col_b  = col_a;
            line_b = state.line;
        end

        if (item.in_byte <= ASCII_MAX)
            acc_new = {24'd0, item.in_byte};
        else if (item.in_byte <= CONT_MAX)
            acc_new = {state.acc[AccW-7:0], item.in_byte[5:0] & CONT_MASK[5:0]};
        else if (item.in_byte <= LEAD2_MAX)
            acc_new = {24'd0, item.in_byte & LEAD2_MASK};
        else if (item.in_byte <= LEAD3_MAX)
            acc_new = {24'd0, item.in_byte & LEAD3_MASK};
        else
            acc_new = {24'd0, item.in_byte & LEAD4_MASK};

        emit1 = item.final_byte && (acc_new <= CP_LIMIT);

        res0.out_byte      = state.acc[7:0];
        res0.invalid_code  = (state.acc > LATIN1_MAX);
        res0.line_number   = state.line;
        res0.column_number = state.col;
        res0.last_of_run   = !emit1;

        res1.out_byte      = acc_new[7:0];
        res1.invalid_code  = (acc_new > LATIN1_MAX);
        res1.line_number   = line_b;
        res1.column_number = col_b;
        res1.last_of_run   = 1'b1;

        push.n_res = {1'b0, emit0} + {1'b0, emit1};
        push.res_a = emit0 ? res0 : res1;
        push.res_b = res1;

        if (item.final_byte)
            state_next = STATE_RESET;
        else
        begin
            state_next.acc     = acc_new;
            state_next.pending = 1'b1;
            state_next.line    = line_b;
            state_next.col     = col_b;
        end
    end

endmodule

// ----- src/u2l_outq.sv -----
// Four-entry result queue that takes up to two results per cycle and returns one.
module u2l_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_en,
    input  u2l_pkg::u2l_push_t push,
    output logic               room,
    output logic [u2l_pkg::QCntW-1:0] level,
    u2l_out_if.source          latin1
);
    import u2l_pkg::*;

    u2l_out_t          q_reg [QDepth];
    logic [QPtrW-1:0]  wr_reg;
    logic [QPtrW-1:0]  wr_next;
    logic [QPtrW-1:0]  rd_reg;
    logic [QPtrW-1:0]  rd_next;
    logic [QCntW-1:0]  count_reg;
    logic [QCntW-1:0]  count_next;
    logic [1:0]        n_push;
    logic              pop;

    always_comb
    begin
        n_push     = push_en ? push.n_res : 2'd0;
        pop        = latin1.valid && latin1.ready;
        wr_next    = wr_reg + QPtrW'(n_push);
        rd_next    = rd_reg + QPtrW'(pop);
        count_next = count_reg + QCntW'(n_push) - QCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            q_reg[wr_reg] <= push.res_a;
        if (n_push == 2'd2)
            q_reg[wr_reg + QPtrW'(1)] <= push.res_b;
    end

    // Two free slots are needed because one byte can produce two characters.
    assign room         = (count_reg <= QCntW'(QDepth - 2));
    assign level        = count_reg;
    assign latin1.valid = (count_reg != '0);
    assign latin1.data  = q_reg[rd_reg];

endmodule

// ----- src/utf8_to_latin1_stream_core.sv -----
// A character is written into the registered result queue when the byte that settles it is accepted.
// One byte per cycle while the result queue has room; a byte that settles two characters puts both in the queue.
// The result queue holds four entries and takes a byte while at least two are free.
// Reset (rst_n low, asynchronous) clears the accumulator, sets line and column to one,
// and empties the result queue.
module utf8_to_latin1_stream_core (
    input  logic      clk,
    input  logic      rst_n,
    u2l_in_if.sink    utf8,
    u2l_out_if.source latin1
);
    import u2l_pkg::*;

    u2l_state_t       state_reg;
    u2l_state_t       state_next;
    u2l_push_t        push;
    logic             room;
    logic             fire;
    logic [QCntW-1:0] level;

    assign utf8.ready = room;
    assign fire       = utf8.valid && room;

    u2l_decode u_decode (
        .item       (utf8.data),
        .state      (state_reg),
        .state_next (state_next),
        .push       (push)
    );

    u2l_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (fire),
        .push    (push),
        .room    (room),
        .level   (level),
        .latin1  (latin1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (fire)
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QCntW'(QDepth))
        else $error("result queue count exceeds its depth");

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && utf8.data.final_byte) |=>
            (state_reg.acc == '0) && !state_reg.pending &&
            (state_reg.line == CNT_ONE) && (state_reg.col == CNT_ONE))
        else $error("state not back at reset values after final byte");

    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && utf8.data.final_byte) |=> state_reg.line >= $past(state_reg.line))
        else $error("line counter moved backwards within a buffer");
`endif

endmodule
